>>> src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the stable priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int KEY_W   = 16;
  localparam int LEVEL_W = 2;
  localparam int AGE_W   = 8;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int OUT_N_W = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [AGE_W-1:0]   age;
    logic [LEVEL_W-1:0] level;
    logic [KEY_W-1:0]   key;
  } entry_t;

  // Row-wide command, one bit per kind of move
  typedef struct packed {
    logic ins;
    logic pop;
    logic rot;
  } spq_cmd_t;

  // Where a cell sits relative to the fill level
  typedef struct packed {
    logic occ;
    logic at_fill;
    logic is_last;
  } spq_pos_t;

endpackage

>>> src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the queue: holds an entry, compares its level for insertion
// and shifts to or from its neighbors.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic              clk,
  input  spq_pkg::spq_cmd_t cmd,
  input  spq_pkg::spq_pos_t pos,
  input  spq_pkg::entry_t   new_ent,
  input  spq_pkg::entry_t   left_ent,
  input  spq_pkg::entry_t   right_ent,
  input  spq_pkg::entry_t   head_ent,
  input  logic              gt_prev,
  output logic              gt,
  output spq_pkg::entry_t   ent
);
  import spq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  assign gt  = pos.occ && (ent_r.level > new_ent.level);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins) begin
      if (gt_prev) begin
        ent_nxt = left_ent;
      end else if (gt || pos.at_fill) begin
        ent_nxt = new_ent;
      end
    end else if (cmd.pop) begin
      ent_nxt = right_ent;
    end else if (cmd.rot) begin
      ent_nxt = pos.is_last ? head_ent : right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

>>> src/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded queue in priority order (level 0 most urgent, lower levels rank ahead),
// first come first served within a level, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Insert, pop and the unused opcode: a beat is accepted and its result beat
// is registered on the next edge, so with the result side ready one
// operation completes every cycle. A search rotates the whole row once
// through its head, one cell per cycle (a search of an empty queue answers
// as the other operations do); no beat is accepted during the rotation. A
// new beat is accepted only once the previous result beat has been taken or
// is being taken in the same cycle.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // level[1:0], entry_key[17:2], entry_age[25:18]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // head_key[15:0], head_level[17:16], head_age[25:18],
                                  // occupancy[30:26], match_count[35:31]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic               state_r, state_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [IW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      mcnt_r, mcnt_nxt;
  logic [KEY_W-1:0]   skey_r, skey_nxt;
  logic [LEVEL_W-1:0] flvl_r, flvl_nxt;
  logic [AGE_W-1:0]   fage_r, fage_nxt;

  logic               ovalid_r, ovalid_nxt;
  logic [STAT_W-1:0]  ostat_r, ostat_nxt;
  logic [KEY_W-1:0]   okey_r, okey_nxt;
  logic [LEVEL_W-1:0] olvl_r, olvl_nxt;
  logic [AGE_W-1:0]   oage_r, oage_nxt;
  logic [OUT_N_W-1:0] oocc_r, oocc_nxt;
  logic [OUT_N_W-1:0] omat_r, omat_nxt;

  logic          acc;
  logic [OP_W-1:0] op;
  entry_t        new_ent;
  spq_cmd_t      cmd;
  logic          full;
  logic          empty;
  logic          hit;
  logic          last_step;
  logic [CW-1:0] last_idx;

  entry_t        ents [DEPTH];
  logic          gts  [DEPTH];
  spq_pos_t      poss [DEPTH];

  assign op            = in_tuser;
  assign new_ent.level = in_tdata[1:0];
  assign new_ent.key   = in_tdata[17:2];
  assign new_ent.age   = in_tdata[25:18];

  assign in_tready = (state_r == ST_IDLE) && (!ovalid_r || out_tready);
  assign acc       = in_tvalid && in_tready;
  assign full      = (fill_r == CW'(DEPTH));
  assign empty     = (fill_r == '0);
  assign last_idx  = fill_r - CW'(1);

  assign cmd.ins = acc && (op == OP_INSERT) && !full;
  assign cmd.pop = acc && (op == OP_POP) && !empty;
  assign cmd.rot = (state_r == ST_SEARCH);

  assign hit       = (ents[0].key == skey_r);
  assign last_step = (CW'(cnt_r) == last_idx);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   gt_prev;

    if (i == 0) begin : g_first
      assign left_ent = new_ent;
      assign gt_prev  = 1'b0;
    end else begin : g_mid
      assign left_ent = ents[i-1];
      assign gt_prev  = gts[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_ent = ents[i];
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end

    assign poss[i].occ     = (CW'(i) < fill_r);
    assign poss[i].at_fill = (CW'(i) == fill_r);
    assign poss[i].is_last = (CW'(i) == last_idx);

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .pos       (poss[i]),
      .new_ent   (new_ent),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .head_ent  (ents[0]),
      .gt_prev   (gt_prev),
      .gt        (gts[i]),
      .ent       (ents[i])
    );
  end

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    cnt_nxt    = cnt_r;
    mcnt_nxt   = mcnt_r;
    skey_nxt   = skey_r;
    flvl_nxt   = flvl_r;
    fage_nxt   = fage_r;
    ovalid_nxt = ovalid_r && !out_tready;
    ostat_nxt  = ostat_r;
    okey_nxt   = okey_r;
    olvl_nxt   = olvl_r;
    oage_nxt   = oage_r;
    oocc_nxt   = oocc_r;
    omat_nxt   = omat_r;

    if (cmd.ins) begin
      fill_nxt = fill_r + CW'(1);
    end else if (cmd.pop) begin
      fill_nxt = fill_r - CW'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          ostat_nxt = STAT_OK;
          okey_nxt  = '0;
          olvl_nxt  = '0;
          oage_nxt  = '0;
          omat_nxt  = '0;
          oocc_nxt  = OUT_N_W'(fill_nxt);
          if (op == OP_INSERT && full) begin
            ostat_nxt = STAT_FULL;
          end
          if (op == OP_POP) begin
            if (empty) begin
              ostat_nxt = STAT_EMPTY;
            end else begin
              okey_nxt = ents[0].key;
              olvl_nxt = ents[0].level;
              oage_nxt = ents[0].age;
            end
          end
          if (op == OP_SEARCH && !empty) begin
            state_nxt = ST_SEARCH;
            cnt_nxt   = '0;
            mcnt_nxt  = '0;
            skey_nxt  = new_ent.key;
            flvl_nxt  = '0;
            fage_nxt  = '0;
          end else begin
            ovalid_nxt = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          mcnt_nxt = mcnt_r + CW'(1);
          if (mcnt_r == '0) begin
            flvl_nxt = ents[0].level;
            fage_nxt = ents[0].age;
          end
        end
        cnt_nxt = cnt_r + IW'(1);
        if (last_step) begin
          state_nxt  = ST_IDLE;
          ovalid_nxt = 1'b1;
          ostat_nxt  = STAT_OK;
          okey_nxt   = '0;
          olvl_nxt   = flvl_nxt;
          oage_nxt   = fage_nxt;
          oocc_nxt   = OUT_N_W'(fill_r);
          omat_nxt   = OUT_N_W'(mcnt_nxt);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    mcnt_r  <= mcnt_nxt;
    skey_r  <= skey_nxt;
    flvl_r  <= flvl_nxt;
    fage_r  <= fage_nxt;
    ostat_r <= ostat_nxt;
    okey_r  <= okey_nxt;
    olvl_r  <= olvl_nxt;
    oage_r  <= oage_nxt;
    oocc_r  <= oocc_nxt;
    omat_r  <= omat_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = ostat_r;
  assign out_tdata  = {4'b0000, omat_r, oocc_r, oage_r, olvl_r, okey_r};

endmodule
